// ===== hw/rtl/ssc_pkg.sv =====
// Package for the subset sum counter: widths and default sizes.
`default_nettype none

package ssc_pkg;

  // Default table span and count width
  localparam int SSC_MAX_SUM     = 1023;
  localparam int SSC_COUNT_WIDTH = 32;

  // Fixed field widths
  localparam int ELEM_W   = 16;
  localparam int TARGET_W = 10;
  localparam int RESULT_W = 32;

endpackage

`default_nettype wire

// ===== hw/rtl/ssc_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module ssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic      [WIDTH-1:0]         rd_a_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic      [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_sat_add.sv =====
// Saturating adder for two table counts.
`default_nettype none

module ssc_sat_add #(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] sum
);

  logic [WIDTH:0] full;

  assign full = {1'b0, a} + {1'b0, b};
  // carry out means the true sum passed the counter maximum
  assign sum  = full[WIDTH] ? {WIDTH{1'b1}} : full[WIDTH-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_report.sv =====
// Result formatter: clips the count to 32 bits and raises the saturation flag; a target past the table gives 0.
`default_nettype none

module ssc_report
  import ssc_pkg::*;
#(
  parameter int MAX_SUM     = SSC_MAX_SUM,
  parameter int COUNT_WIDTH = SSC_COUNT_WIDTH
) (
  input  wire logic [COUNT_WIDTH-1:0] count,
  input  wire logic [TARGET_W-1:0]    target,
  output logic      [RESULT_W-1:0]    subset_count,
  output logic                        saturated
);

  logic [63:0] cnt64;
  logic        in_range;
  logic        too_wide;

  assign cnt64    = 64'(count);
  assign in_range = 32'(target) <= 32'(MAX_SUM);
  assign too_wide = |cnt64[63:RESULT_W];

  always_comb begin
    if (!in_range) begin
      subset_count = '0;
      saturated    = 1'b0;
    end else begin
      subset_count = too_wide ? {RESULT_W{1'b1}} : cnt64[RESULT_W-1:0];
      saturated    = (&count) | too_wide;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/subset_sum_counter.sv =====
// Top level of the subset sum counter: sequencer, count table RAM and result register.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata[15:0] element_value, tlast last_element
//  out_    | out | out_tvalid / out_tready| tdata[31:0] subset_count, tuser[0] saturated
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data[9:0] target_sum (always ready)
//
// An element e <= MAX_SUM is accepted, then the table is updated one entry per cycle
// from MAX_SUM down to e through the two-read/one-write RAM, and a drain state lands
// the final write. A larger element is only accepted and changes no count.
// A last word then reads the target entry and rewrites all MAX_SUM + 1 table entries
// (1 at sum 0, 0 elsewhere); reset runs the same clearing sweep.
// in_tready is low while a word is worked on or the table is being cleared; the
// result register lets the next set start while a result waits on out_tready.
`default_nettype none

module subset_sum_counter
  import ssc_pkg::*;
#(
  parameter int MAX_SUM     = SSC_MAX_SUM,
  parameter int COUNT_WIDTH = SSC_COUNT_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input words
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [ELEM_W-1:0]   in_tdata,   // [15:0] element_value
  input  wire logic                in_tlast,   // last_element
  // results
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [RESULT_W-1:0] out_tdata,  // [31:0] subset_count
  output logic      [0:0]          out_tuser,  // [0] saturated
  // configuration
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [TARGET_W-1:0] cfg_data    // [9:0] target_sum
);

  localparam int DEPTH = MAX_SUM + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_SUM);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DRAIN,
    ST_RPT_RD,
    ST_RPT
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;     // walk pointer (update and clear)
  logic [AW-1:0]         elem_r, elem_nxt;     // current element, known to fit
  logic                  last_r, last_nxt;
  logic                  wv_r, wv_nxt;         // write-back pending
  logic [AW-1:0]         waddr_r, waddr_nxt;
  logic [TARGET_W-1:0]   target_r, target_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [RESULT_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic                  out_sat_r, out_sat_nxt;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [COUNT_WIDTH-1:0] ram_wr_data;
  logic [AW-1:0]         rd_a_addr, rd_b_addr;
  logic [COUNT_WIDTH-1:0] rd_a_data, rd_b_data;
  logic [COUNT_WIDTH-1:0] merged;
  logic [AW-1:0]         tgt_addr;
  logic [RESULT_W-1:0]   rpt_count;
  logic                  rpt_sat;
  logic                  elem_fits;
  logic                  out_free;

  ssc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // count[s] + count[s - e], both read from the RAM in the previous cycle
  ssc_sat_add #(
    .WIDTH (COUNT_WIDTH)
  ) u_add (
    .a   (rd_a_data),
    .b   (rd_b_data),
    .sum (merged)
  );

  ssc_report #(
    .MAX_SUM     (MAX_SUM),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_report (
    .count        (rd_a_data),
    .target       (target_r),
    .subset_count (rpt_count),
    .saturated    (rpt_sat)
  );

  assign tgt_addr  = AW'(target_r);
  assign elem_fits = in_tdata <= ELEM_W'(MAX_SUM);
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    elem_nxt       = elem_r;
    last_nxt       = last_r;
    wv_nxt         = 1'b0;
    waddr_nxt      = addr_r;
    target_nxt     = cfg_valid ? cfg_data : target_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_sat_nxt    = out_sat_r;

    ram_wr_en   = wv_r;
    ram_wr_addr = waddr_r;
    ram_wr_data = merged;
    rd_a_addr   = addr_r;
    rd_b_addr   = addr_r - elem_r;

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr_r;
        ram_wr_data = (addr_r == '0) ? COUNT_WIDTH'(1) : '0;
        if (addr_r == TOP_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          last_nxt = in_tlast;
          if (elem_fits) begin
            addr_nxt  = TOP_ADDR;
            elem_nxt  = AW'(in_tdata);
            state_nxt = ST_UPDATE;
          end else if (in_tlast) begin
            // element beyond the table leaves every count unchanged
            state_nxt = ST_RPT_RD;
          end
        end
      end
      ST_UPDATE: begin
        wv_nxt    = 1'b1;
        waddr_nxt = addr_r;
        if (addr_r == elem_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_RPT_RD : ST_IDLE;
      end
      ST_RPT_RD: begin
        rd_a_addr = tgt_addr;
        state_nxt = ST_RPT;
      end
      ST_RPT: begin
        rd_a_addr = tgt_addr;  // hold so the read data stays put while we wait
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = rpt_count;
          out_sat_nxt    = rpt_sat;
          addr_nxt       = '0;
          state_nxt      = ST_CLEAR;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= '0;
      last_r       <= 1'b0;
      wv_r         <= 1'b0;
      target_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      last_r       <= last_nxt;
      wv_r         <= wv_nxt;
      target_r     <= target_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    elem_r      <= elem_nxt;
    waddr_r     <= waddr_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_sat_r;

  // a new word never meets a write-back still in flight
  a_no_wb_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !wv_r)
    else $error("write-back pending while accepting");

  // the lower read never passes the walk pointer, so it always sees the old count
  a_low_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> (elem_r <= addr_r))
    else $error("lower read above walk pointer");

  // a write-back always targets the entry read in the previous cycle
  a_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (wv_r && waddr_r == $past(addr_r)))
    else $error("write-back address mismatch");

  // a report loads the result register and then clears the table
  a_rpt_to_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RPT && out_free) |=> (out_tvalid_r && state_r == ST_CLEAR))
    else $error("report not followed by result and clear");

endmodule

`default_nettype wire

// ===== dv/subset_sum_counter_tb.sv =====
// Self-checking testbench for subset_sum_counter: directed sets plus random sets.
`default_nettype none

module subset_sum_counter_tb;
  import ssc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Table span and counter ceiling mirror the defaults the block is built with
  localparam int MAX_SUM = SSC_MAX_SUM;
  localparam longint unsigned COUNT_CEIL = (64'd1 << SSC_COUNT_WIDTH) - 64'd1;
  localparam longint unsigned REPORT_CEIL = 64'h0000_0000_FFFF_FFFF;
  // Worst case for one word to clear the block: a full sweep for the
  // element, then the target read and a full clearing sweep, plus slack
  localparam int DRAIN_CYCLES = 2 * MAX_SUM + 16;
  localparam int RANDOM_ITEMS_PER_PHASE = 75;

  // One expected result word
  typedef struct packed {
    logic [RESULT_W-1:0] count;
    logic                saturated;
  } subset_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ELEM_W-1:0]   in_tdata = '0;    // [15:0] element_value
  logic                in_tlast = 1'b0;  // last_element

  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [RESULT_W-1:0] out_tdata;        // [31:0] subset_count
  logic [0:0]          out_tuser;        // [0] saturated

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TARGET_W-1:0] cfg_data = '0;    // [9:0] target_sum

  subset_sum_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: number of subsets reaching each sum so far in this set
  longint unsigned ways_to_sum [0:MAX_SUM];
  logic [TARGET_W-1:0] target_now = '0;
  subset_result_t expected_counts [$];

  int fail_count     = 0;
  int elements_sent  = 0;
  int sets_closed    = 0;
  int results_seen   = 0;
  int saturated_seen = 0;
  int stall_left     = 0;
  bit quiet_mode     = 1'b0;   // no gaps and no back-pressure while set

  function automatic void clear_ways();
    foreach (ways_to_sum[s]) ways_to_sum[s] = 0;
    ways_to_sum[0] = 1;
  endfunction

  // Fold one accepted element into the table; a last word also predicts
  // the count for the current target and starts a fresh set.
  function automatic void absorb_element(input logic [ELEM_W-1:0] value, input bit last);
    longint unsigned acc;
    int e;
    subset_result_t res;
    e = int'(value);
    // Walk downwards so the lower entries still hold the counts from before
    // this element; a zero element simply doubles each entry.
    if (e <= MAX_SUM) begin
      for (int s = MAX_SUM; s >= e; s--) begin
        acc = ways_to_sum[s] + ways_to_sum[s - e];
        ways_to_sum[s] = (acc > COUNT_CEIL) ? COUNT_CEIL : acc;
      end
    end
    if (last) begin
      acc = ways_to_sum[target_now];
      res.saturated = (acc == COUNT_CEIL);
      if (acc > REPORT_CEIL) begin
        acc = REPORT_CEIL;
        res.saturated = 1'b1;
      end
      res.count = acc[RESULT_W-1:0];
      expected_counts.push_back(res);
      sets_closed++;
      clear_ways();
    end
  endfunction

  // Sender gaps: mostly none or short, now and then long enough to span
  // a whole table sweep
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 40);
    return $urandom_range(300, 2500);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 80);
    return $urandom_range(800, 3000);
  endfunction

  // Hand one word to the block; the table is predicted on acceptance.
  // in_tvalid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_element(input logic [ELEM_W-1:0] value, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    absorb_element(value, last);
    elements_sent++;
  endtask

  // Stop sending, let every expected word drain out, then allow for a
  // sweep still running on a word that gives no result.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [TARGET_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    target_now = value;
    cfg_valid <= 1'b0;
  endtask

  // Compare every result word with the oldest prediction, and drive
  // back-pressure on the result side.
  always @(posedge clk) begin
    subset_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[0]) saturated_seen++;
      if (expected_counts.size() == 0) begin
        fail_count++;
        $display("%0t: result word with none expected: count=%0d saturated=%0b",
                 $time, out_tdata, out_tuser[0]);
      end else begin
        want = expected_counts.pop_front();
        if (out_tdata !== want.count) begin
          fail_count++;
          $display("%0t: subset_count mismatch: expected %0d, got %0d",
                   $time, want.count, out_tdata);
        end
        if (out_tuser[0] !== want.saturated) begin
          fail_count++;
          $display("%0t: saturated mismatch: expected %0b, got %0b",
                   $time, want.saturated, out_tuser[0]);
        end
      end
    end
    if (quiet_mode) stall_left = 0;
    else if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 255) == 0) stall_left = pick_stall();
    out_tready <= (stall_left == 0);
  end

  // Reset target of 0, elements at both ends of the field, elements past
  // the table, and the top target with a pair that reaches it.
  task automatic test_extremes();
    send_element(16'h0000, 1'b1);       // zero element doubles sum 0
    send_element(16'hFFFF, 1'b1);       // past the table: nothing changes
    wait_idle();
    write_target(TARGET_W'(MAX_SUM));
    send_element(16'(MAX_SUM), 1'b1);
    send_element(16'(MAX_SUM + 1), 1'b0);
    send_element(16'h0001, 1'b0);
    send_element(16'(MAX_SUM - 1), 1'b0);
    send_element(16'h0000, 1'b1);
    send_element(16'h8000, 1'b0);
    send_element(16'd512, 1'b0);
    send_element(16'd511, 1'b1);
  endtask

  // The report uses the target in force when the last word arrives,
  // even if it changed while the set was being built.
  task automatic test_target_change_mid_set();
    wait_idle();
    write_target(10'd5);
    send_element(16'd2, 1'b0);
    send_element(16'd3, 1'b0);
    wait_idle();
    write_target(10'd3);
    send_element(16'd0, 1'b1);
    send_element(16'd3, 1'b1);
  endtask

  // 32 zero elements take sum 0 past the counter ceiling; the next set
  // must start from a clean table.
  task automatic test_saturation();
    wait_idle();
    write_target(10'd0);
    for (int i = 0; i < 31; i++) send_element(16'h0000, 1'b0);
    send_element(16'h0000, 1'b1);
    send_element(16'h0000, 1'b1);
  endtask

  // Elements are mostly drawn at or below the target so sums actually
  // land on it; the rest is full-width noise and values round the table edge.
  function automatic logic [ELEM_W-1:0] pick_element(input int tgt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ELEM_W'($urandom_range(0, tgt));
    if (r < 75) return ELEM_W'($urandom_range(0, 3));
    if (r < 90) return ELEM_W'($urandom_range(0, 65535));
    return ELEM_W'($urandom_range(MAX_SUM - 3, MAX_SUM + 3));
  endfunction

  task automatic test_random_sets(input int tgt, input bit quiet);
    int sent;
    int len;
    wait_idle();
    write_target(TARGET_W'(tgt));
    quiet_mode = quiet;
    sent = 0;
    while (sent < RANDOM_ITEMS_PER_PHASE) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_element(pick_element(tgt), i == len - 1);
      end
      sent += len;
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    clear_ways();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // table clears itself after reset; in_tready holds the first word off

    test_extremes();
    test_target_change_mid_set();
    test_saturation();

    test_random_sets(MAX_SUM, 1'b0);
    test_random_sets(0, 1'b0);
    test_random_sets($urandom_range(2, 60), 1'b1);
    test_random_sets(1, 1'b0);
    test_random_sets($urandom_range(61, MAX_SUM - 1), 1'b0);
    test_random_sets(512, 1'b0);

    wait_idle();

    $display("sent %0d element words in %0d sets over targets 0 to %0d",
             elements_sent, sets_closed, MAX_SUM);
    $display("checked %0d result words, %0d of them saturated, %0d errors",
             results_seen, saturated_seen, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_ram.sv
hw/rtl/ssc_sat_add.sv
hw/rtl/ssc_report.sv
hw/rtl/subset_sum_counter.sv
dv/subset_sum_counter_tb.sv
